[rtl/rmv_pkg.sv]
`default_nettype none

package rmv_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = 8;
    localparam int MEAN_W    = 24;
    localparam int VAR_W     = 40;
    localparam int SD_W      = 24;
    localparam int CNT_W     = 16;
    localparam int TGT_W     = 8;

    localparam logic [TGT_W-1:0] TARGET_RST = TGT_W'(16);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                       op;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean_out;
        logic [VAR_W-1:0]         variance_out;
        logic [SD_W-1:0]          stdev_out;
        logic [CNT_W-1:0]         count_out;
        logic                     ready_res;
    } t_out_beat;

endpackage

`default_nettype wire

[rtl/running_mean_variance.sv]
`default_nettype none

// Channel   Direction  Handshake                        Payload
// in        input      i_in_valid / o_in_ready          i_in  (op, sample)
// out       output     o_out_valid / i_out_ready        o_res (mean, variance, stdev, count, ready)
// cfg       input      i_cfg_wr_en, no wait             i_cfg_wr_data (target_count)
//
// Add beat with one or more samples held: from acceptance to the next acceptance the
// sequencer runs three radix-2 divider runs, a square root and setup steps.
// First sample after clear or reset, or a clear beat: square root only.
// Reset is synchronous; it clears count, mean, variance and restores target_count to 16.
// A new beat is taken while a result waits; the sequencer stalls only in its last step
// if the previous result is still untaken.

module running_mean_variance (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire rmv_pkg::t_in_beat        i_in,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output rmv_pkg::t_out_beat            o_res,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [rmv_pkg::TGT_W-1:0] i_cfg_wr_data
);
    import rmv_pkg::*;

    localparam int K_W      = CNT_W + 1;
    localparam int ABSD_W   = MEAN_W + 1;
    localparam int MUL_W    = ABSD_W;
    localparam int PROD_W   = 2 * (MUL_W + 1);
    localparam int DD_W     = 2 * ABSD_W - FRAC_BITS;
    localparam int MNUM_W   = MEAN_W + CNT_W + 1;
    localparam int DIV_A    = (DD_W > MNUM_W) ? DD_W : MNUM_W;
    localparam int DIV_W    = (DIV_A > VAR_W) ? DIV_A : VAR_W;
    localparam int DSR_W    = K_W;
    localparam int RAD_W    = VAR_W + FRAC_BITS;
    localparam int RT_W     = (RAD_W + 1) / 2;
    localparam int RAD2_W   = 2 * RT_W;
    localparam int SUB_W    = (RT_W + 2 > DSR_W + 1) ? RT_W + 2 : DSR_W + 1;
    localparam int ITER_MAX = (DIV_W > RT_W) ? DIV_W : RT_W;
    localparam int ITER_W   = $clog2(ITER_MAX);
    localparam int VS_W     = DIV_W + 1;

    localparam logic signed [63:0] MEAN_MAX_64 = (64'sd1 <<< (MEAN_W - 1)) - 64'sd1;
    localparam logic signed [63:0] MEAN_MIN_64 = -(64'sd1 <<< (MEAN_W - 1));
    localparam logic [63:0]        SD_MAX_64   = (64'd1 << SD_W) - 64'd1;
    localparam logic [VS_W-1:0]    VAR_MAX_S   = VS_W'({VAR_W{1'b1}});

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_SQ, ST_MMUL, ST_DIV, ST_DEND,
        ST_MADD, ST_MLD, ST_VSUM, ST_ROOT, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        JOB_DD, JOB_MEAN, JOB_VAR
    } t_job;

    t_state                    r_state;
    t_job                      r_job;
    logic [TGT_W-1:0]          r_target;
    logic [CNT_W-1:0]          r_count;
    logic signed [MEAN_W-1:0]  r_mean;
    logic [VAR_W-1:0]          r_var;
    logic signed [MEAN_W-1:0]  r_x;
    logic [K_W-1:0]            r_k;
    logic [ABSD_W-1:0]         r_absd;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [MNUM_W-1:0]  r_mnum;
    logic                      r_mneg;
    logic [DIV_W-1:0]          r_t2;
    logic [VAR_W-1:0]          r_t1;
    logic [DIV_W-1:0]          r_dq;
    logic [DSR_W-1:0]          r_drem;
    logic [DSR_W-1:0]          r_dsor;
    logic [RAD2_W-1:0]         r_rad;
    logic [RT_W+1:0]           r_rrem;
    logic [RT_W-1:0]           r_root;
    logic [ITER_W-1:0]         r_iter;
    t_out_beat                 r_res;
    logic                      r_res_vld;

    logic signed [63:0]        x_wide;
    logic signed [MEAN_W-1:0]  x_clamp;
    logic signed [ABSD_W-1:0]  diff_xm;
    logic [ABSD_W-1:0]         abs_xm;
    logic signed [MUL_W:0]     mul_a;
    logic signed [MUL_W:0]     mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [SUB_W-1:0]          sub_a;
    logic [SUB_W-1:0]          sub_b;
    logic [SUB_W:0]            sub_d;
    logic                      sub_ge;
    logic [VS_W-1:0]           vsum;
    logic [VAR_W-1:0]          nv;
    logic [DIV_W-1:0]          mnum_mag;
    logic signed [MEAN_W-1:0]  mean_mag;
    logic signed [MEAN_W-1:0]  mean_new;
    logic [VAR_W-1:0]          var_t1;
    logic [SD_W-1:0]           sd;
    logic [CNT_W-1:0]          cnt_inc;
    logic                      in_beat;

    assign in_beat     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_res_vld;
    assign o_res       = r_res;

    always_comb begin
        x_wide = 64'($signed(i_in.sample)) <<< FRAC_BITS;
        if (x_wide > MEAN_MAX_64) begin
            x_clamp = MEAN_W'(MEAN_MAX_64);
        end else if (x_wide < MEAN_MIN_64) begin
            x_clamp = MEAN_W'(MEAN_MIN_64);
        end else begin
            x_clamp = MEAN_W'(x_wide);
        end

        diff_xm = ABSD_W'(r_x) - ABSD_W'(r_mean);
        abs_xm  = diff_xm[ABSD_W-1] ? ABSD_W'(-diff_xm) : ABSD_W'(diff_xm);

        // one multiplier: d*d, then old mean times old count
        if (r_state == ST_SQ) begin
            mul_a = $signed((MUL_W+1)'(r_absd));
            mul_b = $signed((MUL_W+1)'(r_absd));
        end else begin
            mul_a = (MUL_W+1)'(r_mean);
            mul_b = $signed((MUL_W+1)'(r_count));
        end
        mul_p = PROD_W'(mul_a * mul_b);

        // one subtractor: divider trial step or square-root trial step
        if (r_state == ST_ROOT) begin
            sub_a = SUB_W'({r_rrem[RT_W-1:0], r_rad[RAD2_W-1 -: 2]});
            sub_b = SUB_W'({r_root, 2'b01});
        end else begin
            sub_a = SUB_W'({r_drem, r_dq[DIV_W-1]});
            sub_b = SUB_W'(r_dsor);
        end
        sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge = !sub_d[SUB_W];

        vsum = VS_W'(r_t1) + VS_W'(r_t2);
        nv   = (vsum > VAR_MAX_S) ? '1 : vsum[VAR_W-1:0];

        mnum_mag = r_mnum[MNUM_W-1] ? DIV_W'(-r_mnum) : DIV_W'(r_mnum);
        mean_mag = MEAN_W'(r_dq);
        mean_new = r_mneg ? -mean_mag : mean_mag;

        // (k-2)v/(k-1) truncated equals v - ceil(v/(k-1))
        var_t1 = r_var - VAR_W'(r_dq) - VAR_W'(r_drem != '0);

        if (64'(r_root) > SD_MAX_64) begin
            sd = '1;
        end else begin
            sd = SD_W'(r_root);
        end

        cnt_inc = (r_count == '1) ? r_count : r_count + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_res_vld <= 1'b0;
            r_target  <= TARGET_RST;
            r_count   <= '0;
            r_mean    <= '0;
            r_var     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_target <= i_cfg_wr_data;
            end
            if (r_res_vld && i_out_ready && r_state != ST_DONE) begin
                r_res_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_rad  <= '0;
                        r_rrem <= '0;
                        r_root <= '0;
                        r_iter <= ITER_W'(RT_W - 1);
                        if (i_in.op == OP_CLEAR) begin
                            r_count <= '0;
                            r_mean  <= '0;
                            r_var   <= '0;
                            r_state <= ST_ROOT;
                        end else if (r_count == '0) begin
                            r_count <= CNT_W'(1);
                            r_mean  <= x_clamp;
                            r_var   <= '0;
                            r_state <= ST_ROOT;
                        end else begin
                            r_x     <= x_clamp;
                            r_k     <= K_W'(r_count) + 1'b1;
                            r_state <= ST_DIFF;
                        end
                    end
                end
                ST_DIFF: begin
                    r_absd  <= abs_xm;
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_prod  <= mul_p;
                    r_state <= ST_MMUL;
                end
                ST_MMUL: begin
                    // d*d >> frac divided by k
                    r_dq    <= DIV_W'(r_prod[PROD_W-1:FRAC_BITS]);
                    r_drem  <= '0;
                    r_dsor  <= r_k;
                    r_iter  <= ITER_W'(DIV_W - 1);
                    r_job   <= JOB_DD;
                    r_prod  <= mul_p;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_dq <= {r_dq[DIV_W-2:0], sub_ge};
                    r_drem <= sub_ge ? sub_d[DSR_W-1:0] : sub_a[DSR_W-1:0];
                    if (r_iter == '0) begin
                        r_state <= ST_DEND;
                    end else begin
                        r_iter <= r_iter - 1'b1;
                    end
                end
                ST_DEND: begin
                    case (r_job)
                        JOB_DD: begin
                            r_t2    <= r_dq;
                            r_state <= ST_MADD;
                        end
                        JOB_MEAN: begin
                            r_mean  <= mean_new;
                            r_dq    <= DIV_W'(r_var);
                            r_drem  <= '0;
                            r_dsor  <= r_k - 1'b1;
                            r_iter  <= ITER_W'(DIV_W - 1);
                            r_job   <= JOB_VAR;
                            r_state <= ST_DIV;
                        end
                        JOB_VAR: begin
                            r_t1    <= var_t1;
                            r_state <= ST_VSUM;
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_MADD: begin
                    r_mnum  <= MNUM_W'(r_prod) + MNUM_W'(r_x);
                    r_state <= ST_MLD;
                end
                ST_MLD: begin
                    r_mneg  <= r_mnum[MNUM_W-1];
                    r_dq    <= mnum_mag;
                    r_drem  <= '0;
                    r_dsor  <= r_k;
                    r_iter  <= ITER_W'(DIV_W - 1);
                    r_job   <= JOB_MEAN;
                    r_state <= ST_DIV;
                end
                ST_VSUM: begin
                    r_var   <= nv;
                    r_count <= cnt_inc;
                    r_rad   <= RAD2_W'(nv) << FRAC_BITS;
                    r_rrem  <= '0;
                    r_root  <= '0;
                    r_iter  <= ITER_W'(RT_W - 1);
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    r_rad  <= r_rad << 2;
                    r_rrem <= sub_ge ? sub_d[RT_W+1:0] : sub_a[RT_W+1:0];
                    r_root <= {r_root[RT_W-2:0], sub_ge};
                    if (r_iter == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_iter <= r_iter - 1'b1;
                    end
                end
                ST_DONE: begin
                    if (!r_res_vld || i_out_ready) begin
                        r_res.mean_out     <= r_mean;
                        r_res.variance_out <= r_var;
                        r_res.stdev_out    <= sd;
                        r_res.count_out    <= r_count;
                        r_res.ready_res    <= (r_count >= CNT_W'(r_target));
                        r_res_vld          <= 1'b1;
                        r_state            <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_clear_zeroes_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_in.op == OP_CLEAR) |=> (r_count == '0 && r_var == '0))
        else $error("clear beat did not zero the statistics");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_drem < r_dsor))
        else $error("divider remainder not below divisor");

    a_var_zero_low_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_W'(1)) |-> (r_var == '0))
        else $error("nonzero variance with fewer than two samples");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && !i_out_ready) |=> $stable(r_res))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[tb/sv/running_mean_variance_test.sv]
`default_nettype none

module running_mean_variance_test;
    import rmv_pkg::*;

    localparam int  STALL_LIMIT  = 2000;
    localparam int  SETTLE_TICKS = 20;
    localparam int  TAIL_TICKS   = 200;
    localparam int  N_PHASES     = 10;
    localparam int  LONG_RUN     = 300;
    localparam int  SHORT_RUN    = 35;

    localparam longint       MEAN_HI = (longint'(1) <<< (MEAN_W - 1)) - 1;
    localparam longint       MEAN_LO = -(longint'(1) <<< (MEAN_W - 1));
    localparam logic [63:0]  VAR_CAP = (64'd1 << VAR_W) - 1;
    localparam logic [63:0]  SD_CAP  = (64'd1 << SD_W) - 1;

    class stats_scoreboard;
        logic [TGT_W-1:0]         target;
        logic [CNT_W-1:0]         count;
        logic signed [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]         variance;
        t_out_beat                pending_stats[$];
        int                       mismatches;

        function new();
            target     = TARGET_RST;
            count      = '0;
            mean       = '0;
            variance   = '0;
            mismatches = 0;
        endfunction

        function void set_target(logic [TGT_W-1:0] v);
            target = v;
        endfunction

        // truncated square root, one result bit per pass from the top
        function automatic logic [SD_W-1:0] root_of(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] t;
            r = '0;
            for (int b = SD_W + 1; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            if (r > SD_CAP) r = SD_CAP;
            return r[SD_W-1:0];
        endfunction

        function void fold_in(t_in_beat b);
            longint      x;
            longint      k;
            longint      d;
            longint      nm;
            logic [63:0] ku;
            logic [63:0] dd;
            logic [63:0] nv;
            t_out_beat   want;
            if (b.op == OP_CLEAR) begin
                count    = '0;
                mean     = '0;
                variance = '0;
            end else begin
                x = longint'(b.sample) * (longint'(1) <<< FRAC_BITS);
                if (x > MEAN_HI) x = MEAN_HI;
                if (x < MEAN_LO) x = MEAN_LO;
                k  = longint'(count) + 1;
                ku = 64'(k);
                d  = x - longint'(mean);
                dd = (d < 0) ? 64'(-d) : 64'(d);
                dd = dd * dd;
                if (count == 0) begin
                    nm = x;
                    nv = '0;
                end else begin
                    nm = (longint'(mean) * (k - 1) + x) / k;
                    if (count == 1)
                        nv = dd / (64'd2 << FRAC_BITS);
                    else
                        nv = ((ku - 2) * {24'd0, variance}) / (ku - 1)
                           + dd / (ku << FRAC_BITS);
                end
                if (nm > MEAN_HI) nm = MEAN_HI;
                if (nm < MEAN_LO) nm = MEAN_LO;
                if (nv > VAR_CAP) nv = VAR_CAP;
                mean     = nm[MEAN_W-1:0];
                variance = nv[VAR_W-1:0];
                if (count != '1) count = count + 1'b1;
            end
            want.mean_out     = mean;
            want.variance_out = variance;
            want.stdev_out    = root_of({24'd0, variance} << FRAC_BITS);
            want.count_out    = count;
            want.ready_res    = (count >= CNT_W'(target));
            pending_stats.push_back(want);
        endfunction

        function void check_stats(t_out_beat got);
            t_out_beat want;
            if (pending_stats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: mean=%0d var=%0d sd=%0d cnt=%0d rdy=%0b",
                             got.mean_out, got.variance_out, got.stdev_out,
                             got.count_out, got.ready_res);
                return;
            end
            want = pending_stats.pop_front();
            if (got.mean_out !== want.mean_out || got.variance_out !== want.variance_out ||
                got.stdev_out !== want.stdev_out || got.count_out !== want.count_out ||
                got.ready_res !== want.ready_res) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("stats mismatch: expected mean=%0d var=%0d sd=%0d cnt=%0d rdy=%0b",
                             want.mean_out, want.variance_out, want.stdev_out,
                             want.count_out, want.ready_res);
                    $display("                actual   mean=%0d var=%0d sd=%0d cnt=%0d rdy=%0b",
                             got.mean_out, got.variance_out, got.stdev_out,
                             got.count_out, got.ready_res);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_in_beat             i_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_out_beat            o_res;
    logic                 i_cfg_wr_en;
    logic [TGT_W-1:0]     i_cfg_wr_data;

    stats_scoreboard      sb = new();
    bit                   calm;
    logic signed [15:0]   sensor_level;
    int                   quiet_cycles = 0;

    logic signed [SAMPLE_W-1:0] extreme_vals [4] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    logic [TGT_W-1:0]           phase_targets [N_PHASES];

    running_mean_variance DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (i_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_res         (o_res),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_stats(o_res);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side backpressure: stall drawn per beat, counted either from the
    // last accepted beat or from the moment the next result shows up
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            int stall;
            stall = calm ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                if ($urandom_range(0, 1) == 1) begin
                    do @(posedge i_clk); while (!o_out_valid);
                    @(negedge i_clk);
                end
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    function automatic t_in_beat sample_beat(logic op, logic signed [SAMPLE_W-1:0] s);
        t_in_beat b;
        b.op     = op;
        b.sample = s;
        return b;
    endfunction

    function automatic t_in_beat sensor_beat(int clear_odds);
        logic signed [SAMPLE_W-1:0] s;
        if (clear_odds != 0 && $urandom_range(0, clear_odds - 1) == 0)
            return sample_beat(OP_CLEAR, 16'($urandom));
        case ($urandom_range(0, 3))
            0: s = 16'($urandom);
            1: s = sensor_level + 16'($urandom_range(0, 64)) - 16'sd32;
            2: s = extreme_vals[$urandom_range(0, 3)];
            default: s = 16'($urandom_range(0, 31)) - 16'sd16;
        endcase
        return sample_beat(OP_ADD, s);
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_beat(t_in_beat b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.fold_in(b);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending_stats.size() != 0) @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    task automatic write_target(logic [TGT_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_target(v);
    endtask

    initial begin
        int run_len;
        int clear_odds;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        calm          = 1'b0;
        sensor_level  = '0;
        phase_targets = '{8'd0, 8'd255, 8'd1, 8'($urandom), 8'd16,
                          8'($urandom), 8'd0, 8'd254, 8'($urandom_range(2, 40)), 8'd2};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, target left at its reset value
        send_beat(sample_beat(OP_ADD, 16'sh8000));   // first sample sets the mean
        send_beat(sample_beat(OP_ADD, 16'sh7FFF));   // second sample, widest spread
        send_beat(sample_beat(OP_ADD, 16'sh8000));
        send_beat(sample_beat(OP_ADD, 16'sh7FFF));
        send_beat(sample_beat(OP_CLEAR, 16'sh7FFF)); // sample bits ignored on clear
        send_beat(sample_beat(OP_CLEAR, 16'shFFFF)); // clear with nothing held
        send_beat(sample_beat(OP_ADD, 16'sh0000));
        send_beat(sample_beat(OP_ADD, 16'sh0000));   // zero spread
        send_beat(sample_beat(OP_ADD, 16'shFFFF));
        for (int i = 0; i < 13; i++)                 // walk the count up to the target
            send_beat(sample_beat(OP_ADD, (i < 6) ? extreme_vals[i % 2] : 16'($urandom)));
        send_beat(sample_beat(OP_CLEAR, 16'sh5A5A));

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            write_target(phase_targets[p]);
            calm         = (p % 4 == 2);
            sensor_level = 16'($urandom);
            // the 255 phase runs long without clears so the flag gets raised
            run_len    = (phase_targets[p] == 8'd255) ? LONG_RUN : SHORT_RUN;
            clear_odds = (phase_targets[p] == 8'd255) ? 0 : $urandom_range(6, 20);
            for (int i = 0; i < run_len; i++)
                send_beat(sensor_beat(clear_odds));
        end

        drain_results();
        repeat (TAIL_TICKS) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending_stats.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/rmv_pkg.sv
rtl/running_mean_variance.sv
tb/sv/running_mean_variance_test.sv
